FILE: rtl/two_class_age_ordered_fifo_unit_defines.svh
// assertion macros for the two-class age-ordered fifo unit
// included by the top level; no other dependencies
`ifndef TWO_CLASS_AGE_ORDERED_FIFO_UNIT_DEFINES_SVH
`define TWO_CLASS_AGE_ORDERED_FIFO_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCAF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcaf same-cycle check failed");
// next-cycle implication
`define TCAF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcaf next-cycle check failed");
`else
`define TCAF_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCAF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/tcaf_pkg.sv
// shared types and constants for the two-class age-ordered fifo unit
// used by tcaf_front, tcaf_back and the top level; no dependencies
package tcaf_pkg;

   // sizes
   localparam int QUEUE_DEPTH = 64;
   localparam int ID_WIDTH    = 16;
   localparam int VAL_W       = 16;
   localparam int TAG_W       = 8;
   localparam int CMDQ_DEPTH  = 2;

   // request kinds on the req_type port
   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // dequeue selectors
   localparam logic signed [VAL_W-1:0] SEL_ANY = 16'sd0;
   localparam logic signed [VAL_W-1:0] SEL_A   = 16'sd1;
   localparam logic signed [VAL_W-1:0] SEL_B   = -16'sd1;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type STAT_ENQUEUED = 2'd0;
   localparam status_type STAT_RELEASED = 2'd1;
   localparam status_type STAT_NONE     = 2'd2;
   localparam status_type STAT_FULL     = 2'd3;

   // classified operation codes
   typedef logic [2:0] op_type;
   localparam op_type OP_ENQ_A    = 3'd0;
   localparam op_type OP_ENQ_B    = 3'd1;
   localparam op_type OP_DEQ_ANY  = 3'd2;
   localparam op_type OP_DEQ_A    = 3'd3;
   localparam op_type OP_DEQ_B    = 3'd4;
   localparam op_type OP_DEQ_NONE = 3'd5;

   // one classified request handed from front to back
   typedef struct packed {
      op_type                   op;
      logic signed [VAL_W-1:0]  id;
   } cmd_type;

endpackage

FILE: rtl/tcaf_front.sv
// front end: accepts requests, classifies them and queues the commands
// depends on tcaf_pkg
module tcaf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [tcaf_pkg::VAL_W-1:0] req_item_value,
   output logic                              cmd_valid,
   output tcaf_pkg::cmd_type                 cmd,
   input  logic                              cmd_pop
);
   import tcaf_pkg::*;

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            new_cmd;
   cmd_type            slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;

   // classify the incoming request
   always_comb begin
      new_cmd.id = req_item_value;
      if (req_type == REQ_ENQUEUE) begin
         if (!req_item_value[VAL_W-1] && (req_item_value != SEL_ANY)) begin
            new_cmd.op = OP_ENQ_A;
         end else begin
            new_cmd.op = OP_ENQ_B;
         end
      end else if (req_item_value == SEL_ANY) begin
         new_cmd.op = OP_DEQ_ANY;
      end else if (req_item_value == SEL_A) begin
         new_cmd.op = OP_DEQ_A;
      end else if (req_item_value == SEL_B) begin
         new_cmd.op = OP_DEQ_B;
      end else begin
         new_cmd.op = OP_DEQ_NONE;
      end
   end

   // command queue control
   assign req_ready = (count_ff != CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign push      = req_valid && req_ready;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: rtl/tcaf_back.sv
// back end: two id/tag memories, queue pointers, arrival counter, result register
// depends on tcaf_pkg
module tcaf_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  tcaf_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tcaf_pkg::status_type                rsp_status,
   output logic signed [tcaf_pkg::VAL_W-1:0]   rsp_released_id
);
   import tcaf_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = TAG_W + ID_WIDTH;

   localparam logic BK_IDLE = 1'b0;
   localparam logic BK_READ = 1'b1;

   // narrow an incoming id to the stored width
   function automatic logic [ID_WIDTH-1:0] to_store(input logic signed [VAL_W-1:0] v);
      logic signed [31:0] wide;
      wide = 32'(v);
      return ID_WIDTH'(wide);
   endfunction

   // sign-extend a stored id and keep the output width
   function automatic logic signed [VAL_W-1:0] to_out(input logic [ID_WIDTH-1:0] s);
      logic signed [ID_WIDTH-1:0] t;
      logic signed [31:0]         wide;
      t    = s;
      wide = 32'(t);
      return VAL_W'(wide);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [ENTRY_W-1:0]       mem_a [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]       mem_b [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]       rd_a_ff, rd_b_ff;
   logic [ENTRY_W-1:0]       wr_data;
   logic                     wr_a, wr_b, rd_en;

   logic                     state_ff, state_in;
   op_type                   cur_op_ff, cur_op_in;
   logic [PTR_W-1:0]         head_a_ff, head_a_in, tail_a_ff, tail_a_in;
   logic [PTR_W-1:0]         head_b_ff, head_b_in, tail_b_ff, tail_b_in;
   logic [CNT_W-1:0]         count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [TAG_W-1:0]         arrival_ff, arrival_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0]  rsp_id_ff, rsp_id_in;

   logic                     out_free;
   logic                     a_ne, b_ne, a_older, take_a, take_b;
   logic [TAG_W-1:0]         age_diff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_data  = {arrival_ff, to_store(cmd.id)};

   // pick which head to release from the registered head entries
   assign a_ne     = (count_a_ff != '0);
   assign b_ne     = (count_b_ff != '0);
   assign age_diff = rd_a_ff[ENTRY_W-1 -: TAG_W] - rd_b_ff[ENTRY_W-1 -: TAG_W];
   assign a_older  = age_diff[TAG_W-1];

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      case (cur_op_ff)
         OP_DEQ_ANY: begin
            if (a_ne && b_ne) begin
               take_a = a_older;
               take_b = !a_older;
            end else begin
               take_a = a_ne;
               take_b = !a_ne && b_ne;
            end
         end
         OP_DEQ_A: take_a = a_ne;
         OP_DEQ_B: take_b = b_ne;
         default: begin
            take_a = 1'b0;
            take_b = 1'b0;
         end
      endcase
   end

   // sequencer: enqueue in one step, dequeue reads heads then releases
   always_comb begin
      state_in      = state_ff;
      cur_op_in     = cur_op_ff;
      head_a_in     = head_a_ff;
      tail_a_in     = tail_a_ff;
      count_a_in    = count_a_ff;
      head_b_in     = head_b_ff;
      tail_b_in     = tail_b_ff;
      count_b_in    = count_b_ff;
      arrival_in    = arrival_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      rd_en         = 1'b0;
      cmd_pop       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_ENQ_A: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     if (count_a_ff == CNT_W'(QUEUE_DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_ENQUEUED;
                        wr_a          = 1'b1;
                        tail_a_in     = ptr_inc(tail_a_ff);
                        count_a_in    = count_a_ff + 1'b1;
                        arrival_in    = arrival_ff + 1'b1;
                     end
                  end
                  OP_ENQ_B: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     if (count_b_ff == CNT_W'(QUEUE_DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_ENQUEUED;
                        wr_b          = 1'b1;
                        tail_b_in     = ptr_inc(tail_b_ff);
                        count_b_in    = count_b_ff + 1'b1;
                        arrival_in    = arrival_ff + 1'b1;
                     end
                  end
                  default: begin
                     rd_en     = 1'b1;
                     cur_op_in = cmd.op;
                     state_in  = BK_READ;
                  end
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
               if (take_a) begin
                  rsp_status_in = STAT_RELEASED;
                  rsp_id_in     = to_out(rd_a_ff[ID_WIDTH-1:0]);
                  head_a_in     = ptr_inc(head_a_ff);
                  count_a_in    = count_a_ff - 1'b1;
               end else if (take_b) begin
                  rsp_status_in = STAT_RELEASED;
                  rsp_id_in     = to_out(rd_b_ff[ID_WIDTH-1:0]);
                  head_b_in     = ptr_inc(head_b_ff);
                  count_b_in    = count_b_ff - 1'b1;
               end else begin
                  rsp_status_in = STAT_NONE;
                  rsp_id_in     = '0;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_a_ff    <= '0;
         tail_a_ff    <= '0;
         count_a_ff   <= '0;
         head_b_ff    <= '0;
         tail_b_ff    <= '0;
         count_b_ff   <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_a_ff    <= head_a_in;
         tail_a_ff    <= tail_a_in;
         count_a_ff   <= count_a_in;
         head_b_ff    <= head_b_in;
         tail_b_ff    <= tail_b_in;
         count_b_ff   <= count_b_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_op_ff     <= cur_op_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   // queue a store, registered head read
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[tail_a_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_a[head_a_ff];
      end
   end

   // queue b store, registered head read
   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[tail_b_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_b_ff <= mem_b[head_b_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_released_id = rsp_id_ff;

endmodule

FILE: rtl/two_class_age_ordered_fifo_unit.sv
// Two-class age-ordered fifo. Requests come in on req_* (valid/ready):
// req_type 0 enqueues req_item_value (positive id to queue A, else queue B,
// each tagged with a shared 8-bit arrival count); req_type 1 dequeues with
// selector 0 (older head of either queue), 1 (A only) or -1 (B only).
// Every request gives exactly one response on rsp_* (valid/ready): a status
// (enqueued, released, nothing to release, queue full) and the released id.
// The back end takes one enqueue per cycle while rsp_ready does not stall it;
// a dequeue first reads the head entries of the id/tag memories into
// registers and makes the release decision from them in the next state, so
// no new command is taken until the release is done.
// A 2-entry command queue sits between the request side and the back end,
// so requests keep being taken while a response waits in the output register.
// When the receiver stalls, the response holds and the back end stops; once
// the command queue fills, req_ready drops.
// Synchronous reset empties both queues, clears the arrival count and drops
// rsp_valid; memory contents are not cleared and need no clearing pass.
// depends on tcaf_pkg, tcaf_front, tcaf_back and the assertion macro header
`include "two_class_age_ordered_fifo_unit_defines.svh"
module two_class_age_ordered_fifo_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic signed [tcaf_pkg::VAL_W-1:0]   req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tcaf_pkg::status_type                rsp_status,
   output logic signed [tcaf_pkg::VAL_W-1:0]   rsp_released_id
);
   import tcaf_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   logic    rsp_no_release;

   // request side: classify and queue
   tcaf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // execution side: queues and responses
   tcaf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_released_id (rsp_released_id)
   );

   // response that carries no released id
   assign rsp_no_release = rsp_valid && (rsp_status != STAT_RELEASED);

   // checks
   `TCAF_ASSERT_IMP(a_pop_needs_cmd, clock, reset, cmd_pop, cmd_valid)
   `TCAF_ASSERT_NXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   `TCAF_ASSERT_IMP(a_id_zero, clock, reset, rsp_no_release, rsp_released_id == '0)

endmodule
